// File: rtl/tgq_pkg.sv
`default_nettype none
package tgq_pkg;
    localparam int PHASE_BITS = 24;
    localparam int GRID_BITS  = 32;
    localparam int AMOUNT_ONE = 65536;

    localparam logic [2:0] OP_HOLD = 3'd0;
    localparam logic [2:0] OP_TICK = 3'd1;
    localparam logic [2:0] OP_BAR  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_RBAR = 3'd4;

    localparam logic [1:0] REG_INC   = 2'd0;
    localparam logic [1:0] REG_DIVS  = 2'd1;
    localparam logic [1:0] REG_AMT   = 2'd2;
    localparam logic [1:0] REG_DELAY = 2'd3;

    localparam logic [8:0] DIVS_RESET = 9'd4;
    localparam logic [23:0] INC_RESET = 24'd16777;
endpackage
`default_nettype wire

// File: rtl/tempo_grid_quantiser_top.sv
`default_nettype none
// channel | direction | handshake
// in      | input     | i_valid / o_stall
// out     | output    | o_valid / i_stall
// cfg     | input     | APB psel/penable/pwrite, pready tied high
// one transaction runs the shared serial remainder unit three times in turn (bar place,
// grid sum and offset, in states S_PLACE, S_R, S_O) between acceptance and the result;
// a reset to bar start adds one run
// reset is synchronous; grid state and registers take their reset values
// o_stall stays high from acceptance until the result is taken
// the result register holds its value while i_stall is high
module tempo_grid_quantiser_top #(
    parameter int PHASE_BITS = tgq_pkg::PHASE_BITS,
    parameter int GRID_BITS  = tgq_pkg::GRID_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [2:0]            i_opcode,
    input  wire logic [31:0]           i_note_grid,
    input  wire logic [23:0]           i_note_phase,
    input  wire logic [8:0]            i_grid_multiple,
    input  wire logic [7:0]            i_grid_offset,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [31:0]                o_grid_marker,
    output logic [23:0]                o_phase,
    output logic [31:0]                o_bar_start,
    output logic [7:0]                 o_place_in_bar,
    output logic                       o_note_due,
    output logic [31:0]                o_quant_grid,
    output logic [23:0]                o_quant_phase,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [3:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    localparam int PW = PHASE_BITS;
    localparam int GW = GRID_BITS;
    localparam int DW = GW + 1;       // grid sum with its carry
    localparam int MW = PW + 10;      // signed move numerator
    localparam int PRW = MW + 18;     // product width

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EVENT = 4'd1;
    localparam logic [3:0] S_PLACE = 4'd2;
    localparam logic [3:0] S_R     = 4'd3;
    localparam logic [3:0] S_O     = 4'd4;
    localparam logic [3:0] S_K     = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    // configuration registers
    logic [PW-1:0] r_inc;
    logic [8:0]    r_divs;
    logic [16:0]   r_amt;
    logic [15:0]   r_delay;
    logic          w_wr;
    logic [1:0]    w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc   <= PW'(tgq_pkg::INC_RESET);
            r_divs  <= tgq_pkg::DIVS_RESET;
            r_amt   <= 17'(tgq_pkg::AMOUNT_ONE);
            r_delay <= '0;
        end else if (w_wr) begin
            case (w_idx)
                tgq_pkg::REG_INC:   r_inc   <= PW'(pwdata);
                tgq_pkg::REG_DIVS:  r_divs  <= pwdata[8:0];
                tgq_pkg::REG_AMT:   r_amt   <= pwdata[16:0];
                tgq_pkg::REG_DELAY: r_delay <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            tgq_pkg::REG_INC:   prdata = 32'(r_inc);
            tgq_pkg::REG_DIVS:  prdata = {23'd0, r_divs};
            tgq_pkg::REG_AMT:   prdata = {15'd0, r_amt};
            tgq_pkg::REG_DELAY: prdata = {16'd0, r_delay};
            default:            prdata = '0;
        endcase
    end

    // effective clamps
    logic [8:0] w_div_eff, w_mult_eff;
    logic [16:0] w_amt_eff;
    assign w_div_eff = (r_divs == 9'd0) ? 9'd1 : (r_divs > 9'd256 ? 9'd256 : r_divs);
    assign w_amt_eff = (r_amt > 17'd65536) ? 17'd65536 : r_amt;

    // state
    logic [3:0]    r_st;
    logic [PW-1:0] r_phase;
    logic [GW-1:0] r_grid, r_nbar;
    logic [2:0]    r_op;
    logic [31:0]   r_ng;
    logic [23:0]   r_np;
    logic [8:0]    r_mult;
    logic [7:0]    r_off;
    logic [8:0]    r_place, r_r, r_o;
    logic [GW-1:0] r_sum;
    logic          r_carry;
    logic signed [MW-1:0]  r_num;
    logic signed [PRW-1:0] r_prod;

    assign w_mult_eff = (r_mult == 9'd0) ? 9'd1 : (r_mult > 9'd256 ? 9'd256 : r_mult);

    // shared remainder unit
    logic          w_start, w_done;
    logic [DW-1:0] w_dnum;
    logic [8:0]    w_dden, w_rem;

    tgq_divmod #(.W(DW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_num(w_dnum), .i_den(w_dden), .o_done(w_done), .o_rem(w_rem)
    );

    logic r_go;
    assign w_start = r_go;
    always_comb begin
        case (r_st)
            S_PLACE: begin w_dnum = {1'b0, r_grid};   w_dden = w_div_eff; end
            S_R:     begin w_dnum = {r_carry, r_sum}; w_dden = w_mult_eff; end
            default: begin w_dnum = DW'(r_off);       w_dden = w_mult_eff; end
        endcase
    end

    // start pulse for each remainder run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go <= 1'b0;
        end else begin
            r_go <= (r_st == S_EVENT) || (w_done && (r_st == S_PLACE || r_st == S_R));
        end
    end

    // tick add
    logic [PW:0] w_tick;
    assign w_tick = {1'b0, r_phase} + {1'b0, r_inc};

    // k and move
    logic [9:0] w_k, w_mk;
    logic signed [10:0] w_mv;
    assign w_k  = ({1'b0, r_r} + {1'b0, w_mult_eff} - {1'b0, r_o}) >= {1'b0, w_mult_eff}
                  ? ({1'b0, r_r} - {1'b0, r_o})
                  : ({1'b0, r_r} + {1'b0, w_mult_eff} - {1'b0, r_o});
    assign w_mk = {1'b0, w_mult_eff} - w_k;
    always_comb begin
        if (16'(w_k) > r_delay) w_mv = $signed({1'b0, w_mk});
        else if (w_k < w_mk)    w_mv = -$signed({1'b0, w_k});
        else                    w_mv = $signed({1'b0, w_mk});
    end

    // final split: floor shift by 16 then phase add
    logic signed [PRW-1:0] w_move, w_total;
    logic signed [PRW-1:0] w_fl;
    logic [GW-1:0] w_neg;
    assign w_move  = r_prod >>> 16;
    assign w_total = w_move + PRW'($signed({1'b0, r_phase}));
    assign w_fl    = w_total >>> PW;
    assign w_neg   = GW'(-w_fl);

    logic r_ovalid;
    assign o_valid = r_ovalid;
    assign o_stall = (r_st != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_phase  <= '0;
            r_grid   <= '0;
            r_nbar   <= GW'(tgq_pkg::DIVS_RESET);
            r_ovalid <= 1'b0;
        end else begin
            case (r_st)
                S_IDLE: if (i_valid) begin
                    r_op <= i_opcode; r_ng <= i_note_grid; r_np <= i_note_phase;
                    r_mult <= i_grid_multiple; r_off <= i_grid_offset;
                    r_st <= S_EVENT;
                end
                S_EVENT: begin
                    case (r_op)
                        tgq_pkg::OP_TICK: begin
                            r_phase <= w_tick[PW-1:0];
                            if (w_tick[PW]) begin
                                r_grid <= r_grid + GW'(1);
                                if (r_grid == r_nbar) r_nbar <= r_nbar + GW'(w_div_eff);
                            end
                        end
                        tgq_pkg::OP_BAR: begin
                            r_phase <= '0; r_grid <= r_nbar;
                            r_nbar  <= r_nbar + GW'(w_div_eff);
                        end
                        tgq_pkg::OP_DIV: begin
                            r_phase <= '0; r_grid <= r_grid + GW'(1);
                            if (r_grid == r_nbar) r_nbar <= r_nbar + GW'(w_div_eff);
                        end
                        default: ;
                    endcase
                    r_st <= S_PLACE;
                end
                S_PLACE: if (w_done) begin
                    if (r_op == tgq_pkg::OP_RBAR) begin
                        r_op <= tgq_pkg::OP_HOLD;
                        r_phase <= '0;
                        if (w_rem != 9'd0) begin
                            r_grid <= r_nbar;
                            r_nbar <= r_nbar + GW'(w_div_eff);
                        end
                    end else begin
                        r_place <= w_rem;
                        r_sum   <= r_grid + GW'(r_delay);
                        r_carry <= (r_grid + GW'(r_delay)) < r_grid;
                        r_st <= S_R;
                    end
                end
                S_R: if (w_done) begin
                    r_r <= w_rem; r_st <= S_O;
                end
                S_O: if (w_done) begin
                    r_o <= w_rem; r_st <= S_K;
                end
                S_K: begin
                    r_num <= MW'(w_mv) * (MW'(1) <<< PW) - MW'($signed({1'b0, r_phase}));
                    r_st  <= S_MUL;
                end
                S_MUL: begin
                    r_prod <= PRW'(r_num) * PRW'($signed({1'b0, w_amt_eff}));
                    r_st   <= S_FIN;
                end
                S_FIN: begin
                    o_grid_marker  <= 32'(r_grid);
                    o_phase        <= 24'(r_phase);
                    o_bar_start    <= 32'(r_grid - GW'(r_place));
                    o_place_in_bar <= r_place[7:0];
                    o_note_due     <= (GW'(r_ng) < r_grid) ||
                                      (GW'(r_ng) == r_grid && PW'(r_np) < r_phase);
                    // a result before zero saturates to the origin
                    if (w_fl < 0 && !r_carry && r_sum < w_neg) begin
                        o_quant_grid <= '0; o_quant_phase <= '0;
                    end else begin
                        o_quant_phase <= 24'(w_total[PW-1:0]);
                        if (w_fl < 0) o_quant_grid <= 32'(r_sum - w_neg);
                        else o_quant_grid <= 32'(r_sum + GW'(w_fl));
                    end
                    r_ovalid <= 1'b1;
                    r_st <= S_OUT;
                end
                S_OUT: if (!i_stall) begin
                    r_ovalid <= 1'b0; r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/tgq_divmod.sv
`default_nettype none
// serial restoring remainder: one dividend bit per cycle
module tgq_divmod #(
    parameter int W = tgq_pkg::GRID_BITS
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_num,
    input  wire logic [8:0]   i_den,
    output logic              o_done,
    output logic [8:0]        o_rem
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0] r_num;
    logic [8:0]   r_den;
    logic [8:0]   r_rem;
    logic [CW-1:0] r_cnt;
    logic         r_busy;
    logic [9:0]   n_shift;

    assign n_shift = {r_rem, r_num[W-1]};
    assign o_done  = r_busy && (r_cnt == CW'(0));
    assign o_rem   = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(W);
        end else if (r_busy) begin
            if (r_cnt == CW'(0)) r_busy <= 1'b0;
            else r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy && r_cnt != CW'(0)) begin
            r_num <= r_num << 1;
            if (n_shift >= {1'b0, r_den}) r_rem <= 9'(n_shift - {1'b0, r_den});
            else r_rem <= 9'(n_shift);
        end
    end
endmodule
`default_nettype wire

// File: rtl/tgq_checker.sv
`default_nettype none
module tgq_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_grid_marker,
    input wire logic [31:0] o_bar_start,
    input wire logic [7:0]  o_place_in_bar
);
    // result held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_grid_marker)) else $error("result dropped");
    // no new input taken while a result waits
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("input open during output");
    // bar start plus place gives the marker
    a_bar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_bar_start + 32'(o_place_in_bar)) == o_grid_marker)
        else $error("bar start mismatch");
    // result valid rises only after acceptance
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall)) else $error("spurious result");
    // an accepted transaction closes the input
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall) else $error("input not closed after accept");
endmodule
bind tempo_grid_quantiser_top tgq_checker u_chk (.*);
`default_nettype wire

// File: tb/tempo_grid_quantiser_top_tb.sv
`timescale 1ns / 1ps
`default_nettype none

module tempo_grid_quantiser_top_tb;

    // one result transaction of the grid
    typedef struct {
        logic [31:0] grid_marker;
        logic [23:0] phase;
        logic [31:0] bar_start;
        logic [7:0]  place_in_bar;
        logic        note_due;
        logic [31:0] quant_grid;
        logic [23:0] quant_phase;
    } grid_pos_t;

    // tempo grid predictor and pending positions
    class grid_scoreboard;
        bit [23:0] inc;
        bit [8:0]  divs;
        bit [16:0] amt;
        bit [15:0] delay;
        bit [23:0] ph;
        bit [31:0] line;
        bit [31:0] next_bar;
        grid_pos_t pending[$];
        int errors;
        int checked;

        function void reset_state();
            inc = tgq_pkg::INC_RESET;
            divs = tgq_pkg::DIVS_RESET;
            amt = 17'd65536;
            delay = 16'd0;
            ph = 0;
            line = 0;
            next_bar = 32'(tgq_pkg::DIVS_RESET);
            pending.delete();
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                tgq_pkg::REG_INC:   inc = val[23:0];
                tgq_pkg::REG_DIVS:  divs = val[8:0];
                tgq_pkg::REG_AMT:   amt = val[16:0];
                tgq_pkg::REG_DELAY: delay = val[15:0];
                default: ;
            endcase
        endfunction

        function longint unsigned divs_eff();
            if (divs == 0) return 1;
            if (divs > 256) return 256;
            return divs;
        endfunction

        function void step_division();
            if (line == next_bar) next_bar = next_bar + 32'(divs_eff());
            line = line + 1;
        endfunction

        function void jump_bar();
            ph = 0;
            line = next_bar;
            next_bar = line + 32'(divs_eff());
        endfunction

        // apply one event and queue the resulting position
        function void note_input(logic [2:0] op, logic [31:0] ng, logic [23:0] np,
                                 logic [8:0] gm, logic [7:0] go);
            longint unsigned mult, dv, place, sum, r, o, k, a, neg;
            longint mv, num, mvq, total, fl;
            bit [24:0] acc;
            bit carry;
            grid_pos_t e;
            mult = (gm == 0) ? 1 : (gm > 256 ? 256 : gm);
            case (op)
                tgq_pkg::OP_TICK: begin
                    acc = {1'b0, ph} + {1'b0, inc};
                    ph = acc[23:0];
                    if (acc[24]) step_division();
                end
                tgq_pkg::OP_BAR: jump_bar();
                tgq_pkg::OP_DIV: begin
                    ph = 0;
                    step_division();
                end
                tgq_pkg::OP_RBAR: begin
                    if (line % divs_eff() == 0) ph = 0;
                    else jump_bar();
                end
                default: ;
            endcase
            dv = divs_eff();
            place = line % dv;
            // remainder of the full sum, carry included
            sum = longint'(line) + longint'(delay);
            r = sum % mult;
            carry = sum[32];
            sum = sum & 64'hFFFF_FFFF;
            o = go % mult;
            k = (r + mult - o) % mult;
            if (k > delay) mv = mult - k;
            else if (k < mult - k) mv = -longint'(k);
            else mv = mult - k;
            a = (amt > 65536) ? 65536 : amt;
            num = mv * (64'sd1 <<< 24) - longint'(ph);
            mvq = (num * longint'(a)) >>> 16;
            total = longint'(ph) + mvq;
            fl = total >>> 24;
            e.quant_phase = 24'(total - fl * (64'sd1 <<< 24));
            if (fl < 0) begin
                neg = -fl;
                if (!carry && sum < neg) begin
                    e.quant_grid = 0;
                    e.quant_phase = 0;
                end else begin
                    e.quant_grid = 32'(sum - neg);
                end
            end else begin
                e.quant_grid = 32'(sum + fl);
            end
            e.grid_marker = line;
            e.phase = ph;
            e.bar_start = line - 32'(place);
            e.place_in_bar = 8'(place);
            e.note_due = (ng < line) || (ng == line && np < ph);
            pending.push_back(e);
        endfunction

        // compare one result with the oldest expected position
        function void check_result(grid_pos_t got);
            grid_pos_t e;
            if (pending.size() == 0) begin
                $error("result with no expected position");
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.grid_marker !== e.grid_marker) begin
                $error("grid_marker exp %h got %h", e.grid_marker, got.grid_marker); errors++;
            end
            if (got.phase !== e.phase) begin
                $error("phase exp %h got %h", e.phase, got.phase); errors++;
            end
            if (got.bar_start !== e.bar_start) begin
                $error("bar_start exp %h got %h", e.bar_start, got.bar_start); errors++;
            end
            if (got.place_in_bar !== e.place_in_bar) begin
                $error("place_in_bar exp %h got %h", e.place_in_bar, got.place_in_bar);
                errors++;
            end
            if (got.note_due !== e.note_due) begin
                $error("note_due exp %b got %b", e.note_due, got.note_due); errors++;
            end
            if (got.quant_grid !== e.quant_grid) begin
                $error("quant_grid exp %h got %h", e.quant_grid, got.quant_grid); errors++;
            end
            if (got.quant_phase !== e.quant_phase) begin
                $error("quant_phase exp %h got %h", e.quant_phase, got.quant_phase); errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_opcode;
    logic [31:0] i_note_grid;
    logic [23:0] i_note_phase;
    logic [8:0]  i_grid_multiple;
    logic [7:0]  i_grid_offset;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_grid_marker;
    logic [23:0] o_phase;
    logic [31:0] o_bar_start;
    logic [7:0]  o_place_in_bar;
    logic        o_note_due;
    logic [31:0] o_quant_grid;
    logic [23:0] o_quant_phase;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    grid_scoreboard sb;
    longint cycles;
    int sent;
    int hold_cycles;
    bit quiet_sink;

    tempo_grid_quantiser_top u_top (.*);

    // clock and timeout
    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2_000_000) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stalls, none in the quiet phase, long hold-off when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else if (quiet_sink) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 9) < 3);
        end
    end

    // monitor: accepted result transactions
    always @(posedge i_clk) begin
        grid_pos_t got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.grid_marker = o_grid_marker;
            got.phase = o_phase;
            got.bar_start = o_bar_start;
            got.place_in_bar = o_place_in_bar;
            got.note_due = o_note_due;
            got.quant_grid = o_quant_grid;
            got.quant_phase = o_quant_phase;
            sb.check_result(got);
        end
    end

    task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // idle cycles between transactions, valid low meanwhile
    task automatic idle_gap();
        int n;
        n = $urandom_range(0, 99);
        n = (n < 60) ? 0 : (n < 95 ? $urandom_range(1, 4) : $urandom_range(20, 300));
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // offer one event transaction and wait for acceptance
    task automatic send_event(logic [2:0] op, logic [31:0] ng, logic [23:0] np,
                              logic [8:0] gm, logic [7:0] go, bit gaps);
        if (gaps) idle_gap();
        i_valid <= 1'b1;
        i_opcode <= op;
        i_note_grid <= ng;
        i_note_phase <= np;
        i_grid_multiple <= gm;
        i_grid_offset <= go;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input(op, ng, np, gm, go);
        sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic random_event(bit gaps);
        logic [2:0] op;
        logic [31:0] ng;
        int r;
        r = $urandom_range(0, 99);
        op = (r < 45) ? tgq_pkg::OP_TICK : (r < 55) ? tgq_pkg::OP_HOLD :
             (r < 68) ? tgq_pkg::OP_BAR : (r < 82) ? tgq_pkg::OP_DIV :
             (r < 95) ? tgq_pkg::OP_RBAR : 3'($urandom_range(5, 7));
        // notes mostly near the current grid so note_due goes both ways
        ng = ($urandom_range(0, 3) == 0) ? $urandom() :
             sb.line + 32'($urandom_range(0, 4)) - 32'd2;
        send_event(op, ng, 24'($urandom()),
                   ($urandom_range(0, 9) == 0) ? 9'($urandom()) : 9'($urandom_range(1, 16)),
                   8'($urandom()), gaps);
    endtask

    initial begin
        int phase_no;
        sb = new();
        sb.reset_state();
        cycles = 0;
        sent = 0;
        hold_cycles = 0;
        quiet_sink = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_opcode <= tgq_pkg::OP_HOLD;
        i_note_grid <= 0;
        i_note_phase <= 0;
        i_grid_multiple <= 9'd1;
        i_grid_offset <= 0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= 0;
        pwdata <= 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset values, every opcode, field extremes
        send_event(tgq_pkg::OP_HOLD, 32'd0, 24'd0, 9'd1, 8'd0, 0);
        send_event(tgq_pkg::OP_TICK, 32'hFFFF_FFFF, 24'hFF_FFFF, 9'd256, 8'd255, 0);
        send_event(tgq_pkg::OP_DIV, 32'd0, 24'd0, 9'd0, 8'd255, 0);
        send_event(tgq_pkg::OP_RBAR, 32'd1, 24'd0, 9'd511, 8'd7, 0);
        send_event(tgq_pkg::OP_RBAR, 32'd4, 24'd1, 9'd3, 8'd2, 0);
        send_event(tgq_pkg::OP_BAR, 32'd8, 24'h80_0000, 9'd5, 8'd4, 0);
        send_event(3'd7, 32'd0, 24'd0, 9'd2, 8'd1, 0);
        send_event(3'd5, 32'hAAAA_AAAA, 24'h55_5555, 9'd170, 8'd85, 0);
        drain();
        cfg_write(tgq_pkg::REG_INC, 32'hFF_FFFF);
        cfg_write(tgq_pkg::REG_DIVS, 32'd0);
        cfg_write(tgq_pkg::REG_AMT, 32'h1_FFFF);
        cfg_write(tgq_pkg::REG_DELAY, 32'hFFFF);
        send_event(tgq_pkg::OP_TICK, 32'd0, 24'd0, 9'd256, 8'd0, 0);
        send_event(tgq_pkg::OP_TICK, 32'd1, 24'hFF_FFFF, 9'd3, 8'd1, 0);
        send_event(tgq_pkg::OP_RBAR, 32'd0, 24'd0, 9'd7, 8'd3, 0);
        drain();
        cfg_write(tgq_pkg::REG_INC, 32'd1);
        cfg_write(tgq_pkg::REG_DIVS, 32'h1FF);
        cfg_write(tgq_pkg::REG_AMT, 32'd0);
        cfg_write(tgq_pkg::REG_DELAY, 32'd0);
        send_event(tgq_pkg::OP_TICK, 32'd0, 24'd0, 9'd4, 8'd3, 0);
        send_event(tgq_pkg::OP_BAR, 32'd0, 24'd0, 9'd4, 8'd3, 0);
        send_event(tgq_pkg::OP_RBAR, 32'd0, 24'd0, 9'd1, 8'd0, 0);
        drain();

        // random phases across register settings
        for (phase_no = 0; phase_no < 8; phase_no++) begin
            cfg_write(tgq_pkg::REG_INC, (phase_no % 3 == 0) ? 32'hFF_FFFF :
                      32'($urandom_range(1, 24'hFF_FFFF)));
            cfg_write(tgq_pkg::REG_DIVS, (phase_no == 1) ? 32'd256 :
                      32'($urandom_range(0, 300)));
            cfg_write(tgq_pkg::REG_AMT, (phase_no == 2) ? 32'd0 :
                      (phase_no == 3) ? 32'd65536 : 32'($urandom_range(0, 70000)));
            cfg_write(tgq_pkg::REG_DELAY, (phase_no == 4) ? 32'hFFFF :
                      32'($urandom_range(0, 20)));
            if (phase_no == 5) begin
                // long receiver hold-off while the sender keeps offering
                hold_cycles <= 2000;
            end
            quiet_sink = (phase_no == 6);
            repeat (105) random_event(phase_no != 6);
            // sender pauses until everything has come back
            drain();
        end
        hold_cycles <= 0;
        quiet_sink = 0;
        drain();

        $display("covered %0d events, %0d results checked, all opcodes and register extremes",
                 sent, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

`default_nettype wire
